### hdl/csim_pkg.sv
// csim_pkg: shared types and constants for the cosine similarity stream block
// depends on nothing
`timescale 1ns / 1ps
package csim_pkg;

  localparam int ACC_W     = 48;
  localparam int PROD_W    = 2 * ACC_W;
  localparam int WIDE_W    = 128;
  localparam int K_W       = 15;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW   = 2;
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [K_W-1:0]   ONE_Q14 = K_W'(16384);

  typedef struct packed {
    logic signed [15:0] elem_a;
    logic signed [15:0] elem_b;
    logic               last_elem;
  } pair_t;

  typedef struct packed {
    logic signed [15:0] similarity;
    logic               zero_norm;
  } result_t;

  // accumulated sums of one finished vector pair
  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic [ACC_W-1:0]        sum_a;
    logic [ACC_W-1:0]        sum_b;
  } acc_t;

endpackage

### hdl/csim_if.sv
// csim_if: valid/ready channels for element pairs and results
// depends on csim_pkg
`timescale 1ns / 1ps
interface csim_pair_if;
  logic             valid;
  logic             ready;
  csim_pkg::pair_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csim_res_if;
  logic              valid;
  logic              ready;
  csim_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/csim_front.sv
// csim_front: registered products, saturating accumulators, one pair per ready cycle
// depends on csim_pkg, csim_if
`timescale 1ns / 1ps
module csim_front (
  input  logic              clk,
  input  logic              rst,
  csim_pair_if.sink         in_ch,
  input  logic              space_ok,
  output logic              push,
  output csim_pkg::acc_t    push_data
);
  import csim_pkg::*;

  logic                    s1_valid;
  logic                    s1_last;
  logic signed [31:0]      s1_dot;
  logic [30:0]             s1_sqa;
  logic [30:0]             s1_sqb;
  logic signed [ACC_W-1:0] dot_acc;
  logic [ACC_W-1:0]        sum_a;
  logic [ACC_W-1:0]        sum_b;
  logic signed [ACC_W:0]   dot_sum;
  logic [ACC_W:0]          sa_sum;
  logic [ACC_W:0]          sb_sum;
  logic signed [ACC_W-1:0] dot_next;
  logic [ACC_W-1:0]        sa_next;
  logic [ACC_W-1:0]        sb_next;
  logic                    accept;

  assign in_ch.ready = space_ok;
  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last <= in_ch.data.last_elem;
      s1_dot  <= 32'(in_ch.data.elem_a) * 32'(in_ch.data.elem_b);
      s1_sqa  <= 31'(unsigned'(32'(in_ch.data.elem_a) * 32'(in_ch.data.elem_a)));
      s1_sqb  <= 31'(unsigned'(32'(in_ch.data.elem_b) * 32'(in_ch.data.elem_b)));
    end
  end

  always_comb begin
    dot_sum = {dot_acc[ACC_W-1], dot_acc} + (ACC_W+1)'(s1_dot);
    sa_sum  = {1'b0, sum_a} + (ACC_W+1)'(s1_sqa);
    sb_sum  = {1'b0, sum_b} + (ACC_W+1)'(s1_sqb);
    priority if (dot_sum > signed'({1'b0, ACC_MAX})) begin
      dot_next = signed'(ACC_MAX);
    end else if (dot_sum < signed'({1'b1, ACC_MIN})) begin
      dot_next = signed'(ACC_MIN);
    end else begin
      dot_next = dot_sum[ACC_W-1:0];
    end
    sa_next = (sa_sum > {1'b0, ACC_MAX}) ? ACC_MAX : sa_sum[ACC_W-1:0];
    sb_next = (sb_sum > {1'b0, ACC_MAX}) ? ACC_MAX : sb_sum[ACC_W-1:0];
  end

  assign push = s1_valid && s1_last;
  assign push_data = '{dot: dot_next, sum_a: sa_next, sum_b: sb_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_acc <= '0;
      sum_a   <= '0;
      sum_b   <= '0;
    end else if (s1_valid) begin
      if (s1_last) begin
        dot_acc <= '0;
        sum_a   <= '0;
        sum_b   <= '0;
      end else begin
        dot_acc <= dot_next;
        sum_a   <= sa_next;
        sum_b   <= sb_next;
      end
    end
  end
endmodule

### hdl/csim_fifo.sv
// csim_fifo: short queue of finished vector sums between front and back
// depends on csim_pkg
`timescale 1ns / 1ps
module csim_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  csim_pkg::acc_t  push_data,
  input  logic            pop,
  output logic            not_empty,
  output logic            space_ok,
  output csim_pkg::acc_t  head
);
  import csim_pkg::*;

  acc_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  // one product stage may still push after ready drops
  assign space_ok  = count < (FIFO_AW+1)'(FIFO_DEPTH - 1);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end
endmodule

### hdl/csim_back.sv
// csim_back: serial squaring/multiply and bitwise root search for the quotient
// depends on csim_pkg, csim_if
`timescale 1ns / 1ps
module csim_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            not_empty,
  input  csim_pkg::acc_t  head,
  output logic            pop,
  csim_res_if.source      out_ch
);
  import csim_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t             state;
  logic               neg;
  logic               zn;
  logic [5:0]         mcnt;
  logic [ACC_W-1:0]   mp_n;
  logic [ACC_W-1:0]   mp_p;
  logic [PROD_W-1:0]  mc_n;
  logic [PROD_W-1:0]  mc_p;
  logic [PROD_W-1:0]  prod_n;
  logic [PROD_W-1:0]  prod_p;
  logic [WIDE_W-1:0]  q;
  logic [WIDE_W-1:0]  rs;
  logic [WIDE_W-1:0]  ps2;
  logic [WIDE_W-1:0]  nsh;
  logic [WIDE_W-1:0]  sum1;
  logic [WIDE_W-1:0]  cand;
  logic [WIDE_W-1:0]  rs_upd;
  logic               fits;
  logic               phase;
  logic [3:0]         bidx;
  logic [K_W-1:0]     k;
  logic [K_W-1:0]     k_cl;
  logic               out_free;
  logic [ACC_W-1:0]   mag;

  assign out_free = !out_ch.valid || out_ch.ready;
  assign pop = (state == ST_IDLE) && not_empty;
  assign mag = head.dot[ACC_W-1] ? ACC_W'(-head.dot) : ACC_W'(head.dot);

  assign cand   = sum1 + ps2;
  assign fits   = cand <= nsh;
  assign rs_upd = fits ? rs + (ps2 << 1) : rs;
  assign k_cl   = (k > ONE_Q14) ? ONE_Q14 : k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (not_empty) begin
          state <= (head.sum_a == '0 || head.sum_b == '0) ? ST_DONE : ST_MUL;
        end
        ST_MUL:  if (mcnt == 6'(ACC_W - 1)) state <= ST_ROOT;
        ST_ROOT: if (phase && bidx == '0) state <= ST_DONE;
        ST_DONE: if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        neg    <= head.dot[ACC_W-1];
        zn     <= (head.sum_a == '0 || head.sum_b == '0);
        k      <= '0;
        mcnt   <= '0;
        mp_n   <= mag;
        mc_n   <= PROD_W'(mag);
        mp_p   <= head.sum_a;
        mc_p   <= PROD_W'(head.sum_b);
        prod_n <= '0;
        prod_p <= '0;
      end
      ST_MUL: begin
        mcnt   <= mcnt + 1'b1;
        if (mp_n[0]) prod_n <= prod_n + mc_n;
        if (mp_p[0]) prod_p <= prod_p + mc_p;
        mp_n   <= mp_n >> 1;
        mp_p   <= mp_p >> 1;
        mc_n   <= mc_n << 1;
        mc_p   <= mc_p << 1;
        // seed the root search while the partial products accumulate
        q      <= '0;
        rs     <= '0;
        phase  <= 1'b0;
        bidx   <= 4'(K_W - 1);
      end
      ST_ROOT: begin
        if (!phase) begin
          sum1 <= q + rs;
          if (bidx == 4'(K_W - 1)) begin
            ps2 <= WIDE_W'(prod_p) << (2 * (K_W - 1));
            nsh <= WIDE_W'(prod_n) << 28;
            sum1 <= '0;
          end
        end else begin
          if (fits) begin
            q <= cand;
            k[bidx] <= 1'b1;
          end
          rs   <= rs_upd >> 1;
          ps2  <= ps2 >> 2;
          bidx <= bidx - 1'b1;
        end
        phase <= !phase;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_ch.data.zero_norm  <= zn;
      out_ch.data.similarity <= zn ? 16'sd0 :
                                (neg ? -signed'({1'b0, k_cl}) : signed'({1'b0, k_cl}));
    end
  end
endmodule

### hdl/cosine_similarity_stream_top.sv
// cosine_similarity_stream_top: streaming cosine similarity of two vectors
// depends on csim_pkg, csim_if, csim_front, csim_fifo, csim_back
`timescale 1ns / 1ps
// Element pairs (signed Q4.12) are taken one per cycle while the queue has
// room, and accumulated into a saturating dot product and two sums of squares.
// The pair flagged last_elem closes the vectors: its sums go into a four-entry
// queue and the accumulators restart, so the next vector may stream in on the
// following cycle. A back end turns each queued entry into one result:
// similarity in signed Q1.14, truncated toward zero, or 0 with zero_norm set
// when either sum of squares is zero. A nonzero entry goes through bit-serial
// squaring and multiply, then a bitwise root search over 15 bits; a zero-norm
// entry skips both. The back end takes a new entry only when idle. Input stalls
// once three sums are queued, leaving room for the pair in the product stage.
module cosine_similarity_stream_top (
  input  logic        clk,
  input  logic        rst,
  csim_pair_if.sink   in_ch,
  csim_res_if.source  out_ch
);
  import csim_pkg::*;

  logic  push;
  acc_t  push_data;
  logic  pop;
  logic  not_empty;
  logic  space_ok;
  acc_t  head;

  // accumulate each transfer, hand finished sums to the queue
  csim_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .space_ok  (space_ok),
    .push      (push),
    .push_data (push_data)
  );

  // decouples the accumulators from the slow quotient unit
  csim_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (not_empty),
    .space_ok  (space_ok),
    .head      (head)
  );

  // quotient unit with registered output
  csim_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );
endmodule
